/* sv/bvs_pkg.sv */
package bvs_pkg;

    localparam int NUM_SETS_DEF      = 8;
    localparam int WORDS_PER_SET_DEF = 16;

    // Operation codes of the func field.
    localparam logic [3:0] FUNC_CLEAR  = 4'd0;
    localparam logic [3:0] FUNC_ADD    = 4'd1;
    localparam logic [3:0] FUNC_HAS    = 4'd2;
    localparam logic [3:0] FUNC_NEXT   = 4'd3;
    localparam logic [3:0] FUNC_UNION  = 4'd4;
    localparam logic [3:0] FUNC_INTER  = 4'd5;
    localparam logic [3:0] FUNC_SUB    = 4'd6;
    localparam logic [3:0] FUNC_EQUAL  = 4'd7;
    localparam logic [3:0] FUNC_MKUNIV = 4'd8;

    // Status codes of a result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_UNIV  = 2'd2;

    // Per-word operation carried out by the shared word unit.
    typedef enum logic [3:0] {
        WOP_ZERO,
        WOP_OR,
        WOP_AND,
        WOP_ANDN,
        WOP_COPY,
        WOP_ADD,
        WOP_HAS,
        WOP_NEXT,
        WOP_EQ
    } word_op_t;

    typedef struct packed {
        word_op_t   op;
        logic       first;
        logic [5:0] bit_sel;
    } alu_ctrl_t;

    typedef struct packed {
        logic [63:0] wr_data;
        logic        wr_en;
        logic        hit;
        logic [5:0]  hit_pos;
        logic        eq;
    } alu_res_t;

endpackage

/* sv/bvs_mem.sv */
module bvs_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [63:0]   rdata_a,
    output logic [63:0]   rdata_b
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* sv/bvs_word_alu.sv */
module bvs_word_alu (
    input  bvs_pkg::alu_ctrl_t ctrl,
    input  logic [63:0]        da,
    input  logic [63:0]        db,
    output bvs_pkg::alu_res_t  res
);

    logic [63:0] masked;
    logic [63:0] lowbit;
    logic [5:0]  enc;

    // The first word of a search ignores the bits below the start position.
    assign masked = ctrl.first ? (da & ({64{1'b1}} << ctrl.bit_sel)) : da;
    assign lowbit = masked & (~masked + 64'd1);

    always_comb begin
        enc = '0;
        for (int j = 0; j < 64; j++) begin
            if (lowbit[j]) begin
                enc = enc | 6'(j);
            end
        end
    end

    always_comb begin
        res         = '0;
        res.hit_pos = enc;
        res.eq      = (da == db);
        case (ctrl.op)
            bvs_pkg::WOP_ZERO: begin
                res.wr_en = 1'b1;
            end
            bvs_pkg::WOP_OR: begin
                res.wr_en   = 1'b1;
                res.wr_data = da | db;
            end
            bvs_pkg::WOP_AND: begin
                res.wr_en   = 1'b1;
                res.wr_data = da & db;
            end
            bvs_pkg::WOP_ANDN: begin
                res.wr_en   = 1'b1;
                res.wr_data = da & ~db;
            end
            bvs_pkg::WOP_COPY: begin
                res.wr_en   = 1'b1;
                res.wr_data = db;
            end
            bvs_pkg::WOP_ADD: begin
                res.wr_en   = 1'b1;
                res.wr_data = da | (64'd1 << ctrl.bit_sel);
            end
            bvs_pkg::WOP_HAS: begin
                res.hit = da[ctrl.bit_sel];
            end
            bvs_pkg::WOP_NEXT: begin
                res.hit = |masked;
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/bit_vector_set_engine.sv */
// Single-word or flag-only operations raise m_valid without a walk over the whole set.
// Walking operations read one word per cycle through the shared word unit; clear, union,
// intersect, subtract and equal walk every word of the set when they do not finish at decode,
// while next stops early on the first word that holds a member.
// Throughput: one transaction at a time; the next is taken once its result has left S_DONE.
// Reset: synchronous, active low; afterwards a clearing pass over all NUM_SETS * WORDS_PER_SET
// words zeroes the word memory while s_ready stays low.
module bit_vector_set_engine #(
    parameter int NUM_SETS      = bvs_pkg::NUM_SETS_DEF,
    parameter int WORDS_PER_SET = bvs_pkg::WORDS_PER_SET_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_func,
    input  logic [2:0]         s_set_a,
    input  logic [2:0]         s_set_b,
    input  logic signed [10:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_flag,
    output logic [9:0]         m_position,
    output logic [1:0]         m_status
);

    localparam int SW    = $clog2(NUM_SETS);
    localparam int WIW   = (WORDS_PER_SET > 1) ? $clog2(WORDS_PER_SET) : 1;
    localparam int DEPTH = NUM_SETS * WORDS_PER_SET;
    localparam int AW    = $clog2(DEPTH);
    localparam int CAP   = WORDS_PER_SET * 64;
    localparam logic [WIW-1:0] LAST_WORD = WIW'(WORDS_PER_SET - 1);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic [SW-1:0]         a_reg;
    logic [SW-1:0]         b_reg;
    bvs_pkg::word_op_t     op_reg;
    logic [5:0]            bit_reg;
    logic [WIW-1:0]        start_idx_reg;
    logic [WIW-1:0]        end_idx_reg;
    logic [WIW-1:0]        rd_idx_reg;
    logic                  issue_done_reg;
    logic                  pv_reg;
    logic [WIW-1:0]        pidx_reg;
    logic                  eq_acc_reg;
    logic [NUM_SETS-1:0]   univ_reg;
    logic                  res_flag_reg;
    logic [9:0]            res_pos_reg;
    logic [1:0]            res_status_reg;
    logic                  m_valid_reg;
    logic                  m_flag_reg;
    logic [9:0]            m_pos_reg;
    logic [1:0]            m_status_reg;

    // Set numbers are reduced modulo NUM_SETS by repeated compare and subtract.
    logic [6:0]    a_tmp;
    logic [6:0]    b_tmp;
    logic [SW-1:0] a_mod;
    logic [SW-1:0] b_mod;

    always_comb begin
        a_tmp = {4'd0, s_set_a};
        b_tmp = {4'd0, s_set_b};
        for (int k = 0; k < 4; k++) begin
            if (a_tmp >= 7'(NUM_SETS)) begin
                a_tmp = a_tmp - 7'(NUM_SETS);
            end
            if (b_tmp >= 7'(NUM_SETS)) begin
                b_tmp = b_tmp - 7'(NUM_SETS);
            end
        end
        a_mod = a_tmp[SW-1:0];
        b_mod = b_tmp[SW-1:0];
    end

    logic        ua;
    logic        ub;
    logic        v_oob;
    logic [10:0] start;
    logic        start_oob;
    logic [31:0] v_word32;
    logic [31:0] s_word32;

    assign ua        = univ_reg[a_mod];
    assign ub        = univ_reg[b_mod];
    assign v_oob     = s_value[10] || ({21'd0, s_value} >= 32'(CAP));
    // Next searches from value + 1, with any negative value treated as start of iteration.
    assign start     = s_value[10] ? 11'd0 : ({1'b0, s_value[9:0]} + 11'd1);
    assign start_oob = ({21'd0, start} >= 32'(CAP));
    assign v_word32  = {22'd0, s_value[9:0]} >> 6;
    assign s_word32  = {21'd0, start} >> 6;

    // Decode of an accepted transaction into either an immediate result or a word walk.
    logic              dec_walk;
    bvs_pkg::word_op_t dec_op;
    logic [WIW-1:0]    dec_first;
    logic [WIW-1:0]    dec_last;
    logic [5:0]        dec_bit;
    logic              dec_flag;
    logic [9:0]        dec_pos;
    logic [1:0]        dec_status;
    logic              dec_univ_wr;
    logic              dec_univ_val;

    always_comb begin
        dec_walk     = 1'b0;
        dec_op       = bvs_pkg::WOP_ZERO;
        dec_first    = '0;
        dec_last     = LAST_WORD;
        dec_bit      = '0;
        dec_flag     = 1'b0;
        dec_pos      = '0;
        dec_status   = bvs_pkg::STATUS_OK;
        dec_univ_wr  = 1'b0;
        dec_univ_val = 1'b0;
        case (s_func)
            bvs_pkg::FUNC_CLEAR: begin
                if (ua) begin
                    dec_status = bvs_pkg::STATUS_UNIV;
                end else begin
                    dec_walk = 1'b1;
                end
            end
            bvs_pkg::FUNC_ADD: begin
                if (!ua) begin
                    if (v_oob) begin
                        dec_status = bvs_pkg::STATUS_RANGE;
                    end else begin
                        dec_walk  = 1'b1;
                        dec_op    = bvs_pkg::WOP_ADD;
                        dec_first = v_word32[WIW-1:0];
                        dec_last  = v_word32[WIW-1:0];
                        dec_bit   = s_value[5:0];
                    end
                end
            end
            bvs_pkg::FUNC_HAS: begin
                if (ua) begin
                    dec_flag = 1'b1;
                end else if (v_oob) begin
                    dec_status = bvs_pkg::STATUS_RANGE;
                end else begin
                    dec_walk  = 1'b1;
                    dec_op    = bvs_pkg::WOP_HAS;
                    dec_first = v_word32[WIW-1:0];
                    dec_last  = v_word32[WIW-1:0];
                    dec_bit   = s_value[5:0];
                end
            end
            bvs_pkg::FUNC_NEXT: begin
                if (!start_oob) begin
                    if (ua) begin
                        dec_flag = 1'b1;
                        dec_pos  = start[9:0];
                    end else begin
                        dec_walk  = 1'b1;
                        dec_op    = bvs_pkg::WOP_NEXT;
                        dec_first = s_word32[WIW-1:0];
                        dec_bit   = start[5:0];
                    end
                end
            end
            bvs_pkg::FUNC_UNION: begin
                if (!ua) begin
                    if (ub) begin
                        dec_univ_wr  = 1'b1;
                        dec_univ_val = 1'b1;
                    end else begin
                        dec_walk = 1'b1;
                        dec_op   = bvs_pkg::WOP_OR;
                    end
                end
            end
            bvs_pkg::FUNC_INTER: begin
                if (ua) begin
                    dec_univ_wr  = 1'b1;
                    dec_univ_val = ub;
                    dec_walk     = 1'b1;
                    dec_op       = bvs_pkg::WOP_COPY;
                end else if (!ub) begin
                    dec_walk = 1'b1;
                    dec_op   = bvs_pkg::WOP_AND;
                end
            end
            bvs_pkg::FUNC_SUB: begin
                if (ua) begin
                    dec_status = bvs_pkg::STATUS_UNIV;
                end else if (ub) begin
                    dec_walk = 1'b1;
                end else begin
                    dec_walk = 1'b1;
                    dec_op   = bvs_pkg::WOP_ANDN;
                end
            end
            bvs_pkg::FUNC_EQUAL: begin
                if (ua || ub) begin
                    dec_flag = ua && ub;
                end else begin
                    dec_walk = 1'b1;
                    dec_op   = bvs_pkg::WOP_EQ;
                end
            end
            bvs_pkg::FUNC_MKUNIV: begin
                dec_univ_wr  = 1'b1;
                dec_univ_val = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Word memory and the shared word unit.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [63:0]        mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic [63:0]        rdata_a;
    logic [63:0]        rdata_b;
    bvs_pkg::alu_ctrl_t alu_ctrl;
    bvs_pkg::alu_res_t  alu_res;

    assign alu_ctrl.op      = op_reg;
    assign alu_ctrl.first   = (pidx_reg == start_idx_reg);
    assign alu_ctrl.bit_sel = bit_reg;

    bvs_word_alu u_alu (
        .ctrl (alu_ctrl),
        .da   (rdata_a),
        .db   (rdata_b),
        .res  (alu_res)
    );

    assign mem_re  = (state_reg == S_WALK) && !issue_done_reg;
    assign raddr_a = AW'(32'(a_reg) * 32'(WORDS_PER_SET) + 32'(rd_idx_reg));
    assign raddr_b = AW'(32'(b_reg) * 32'(WORDS_PER_SET) + 32'(rd_idx_reg));

    always_comb begin
        if (state_reg == S_INIT) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = (state_reg == S_WALK) && pv_reg && alu_res.wr_en;
            mem_waddr = AW'(32'(a_reg) * 32'(WORDS_PER_SET) + 32'(pidx_reg));
            mem_wdata = alu_res.wr_data;
        end
    end

    bvs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // A walk ends on its last word, or as soon as a search finds a member.
    logic        fin;
    logic [31:0] pidx32;

    assign fin    = (state_reg == S_WALK) && pv_reg &&
                    ((pidx_reg == end_idx_reg) ||
                     ((op_reg == bvs_pkg::WOP_NEXT) && alu_res.hit));
    assign pidx32 = 32'(pidx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            clr_addr_reg   <= '0;
            univ_reg       <= '0;
            issue_done_reg <= 1'b0;
            pv_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // The staged result moves to the output register once that register is free.
            if ((state_reg == S_DONE) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        a_reg          <= a_mod;
                        b_reg          <= b_mod;
                        op_reg         <= dec_op;
                        bit_reg        <= dec_bit;
                        start_idx_reg  <= dec_first;
                        rd_idx_reg     <= dec_first;
                        end_idx_reg    <= dec_last;
                        issue_done_reg <= 1'b0;
                        pv_reg         <= 1'b0;
                        eq_acc_reg     <= 1'b1;
                        res_flag_reg   <= dec_flag;
                        res_pos_reg    <= dec_pos;
                        res_status_reg <= dec_status;
                        if (dec_univ_wr) begin
                            univ_reg[a_mod] <= dec_univ_val;
                        end
                        state_reg <= dec_walk ? S_WALK : S_DONE;
                    end
                end
                S_WALK: begin
                    pv_reg   <= !issue_done_reg && !fin;
                    pidx_reg <= rd_idx_reg;
                    if (!issue_done_reg) begin
                        if (rd_idx_reg == end_idx_reg) begin
                            issue_done_reg <= 1'b1;
                        end else begin
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                        end
                    end
                    if (pv_reg) begin
                        eq_acc_reg <= eq_acc_reg && alu_res.eq;
                    end
                    if (fin) begin
                        case (op_reg)
                            bvs_pkg::WOP_HAS: begin
                                res_flag_reg <= alu_res.hit;
                            end
                            bvs_pkg::WOP_NEXT: begin
                                res_flag_reg <= alu_res.hit;
                                res_pos_reg  <= alu_res.hit ?
                                                {pidx32[3:0], alu_res.hit_pos} : 10'd0;
                            end
                            bvs_pkg::WOP_EQ: begin
                                res_flag_reg <= eq_acc_reg && alu_res.eq;
                            end
                            default: begin
                            end
                        endcase
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // The result waits here only while the output register is still full.
                    if (!m_valid_reg || m_ready) begin
                        m_flag_reg   <= res_flag_reg;
                        m_pos_reg    <= res_pos_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_flag     = m_flag_reg;
    assign m_position = m_pos_reg;
    assign m_status   = m_status_reg;

endmodule

/* sv/bvs_checker.sv */
module bvs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_flag,
    input logic [9:0]         m_position,
    input logic [1:0]         m_status
);

    // The clearing pass keeps the input closed right after reset.
    a_ready_low_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // Only one transaction is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on two consecutive cycles");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_flag) && $stable(m_position)
            && $stable(m_status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("undefined status code");

    a_position_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_flag |-> m_position == 10'd0)
        else $error("position set without flag");

endmodule

bind bit_vector_set_engine bvs_checker u_bvs_checker (.*);

/* verif/tb_bit_vector_set_engine.sv */
`timescale 1ns / 100ps

module tb_bit_vector_set_engine;

    localparam int NSETS    = bvs_pkg::NUM_SETS_DEF;
    localparam int NWORDS   = bvs_pkg::WORDS_PER_SET_DEF;
    localparam int CAPACITY = NWORDS * 64;
    localparam int CYCLE_LIMIT = 400000;

    // One expected result of the engine.
    typedef struct packed {
        logic       flag;
        logic [9:0] position;
        logic [1:0] status;
    } set_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_func;
    logic [2:0]         s_set_a;
    logic [2:0]         s_set_b;
    logic signed [10:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic               m_flag;
    logic [9:0]         m_position;
    logic [1:0]         m_status;

    // The predictor keeps its own copy of the set bank.
    logic [63:0] bank_words [NSETS][NWORDS];
    logic        bank_univ  [NSETS];

    set_result_t pending_results[$];
    int          error_count;
    int          cycle_count;
    int          ready_wait;

    bit_vector_set_engine u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_set_a    (s_set_a),
        .s_set_b    (s_set_b),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_flag     (m_flag),
        .m_position (m_position),
        .m_status   (m_status)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Runs one operation on the predicted bank and returns its result.
    function automatic set_result_t apply_set_op(logic [3:0] func, logic [2:0] sa,
                                                 logic [2:0] sb, logic signed [10:0] val);
        set_result_t r;
        int a;
        int b;
        int v;
        int start;
        int found;
        logic [63:0] tmp [NWORDS];
        a = sa % NSETS;
        b = sb % NSETS;
        v = val;
        r = '0;
        case (func)
            bvs_pkg::FUNC_CLEAR: begin
                if (bank_univ[a]) r.status = bvs_pkg::STATUS_UNIV;
                else for (int i = 0; i < NWORDS; i++) bank_words[a][i] = '0;
            end
            bvs_pkg::FUNC_ADD: begin
                if (!bank_univ[a]) begin
                    if (v < 0 || v >= CAPACITY) r.status = bvs_pkg::STATUS_RANGE;
                    else bank_words[a][v / 64][v % 64] = 1'b1;
                end
            end
            bvs_pkg::FUNC_HAS: begin
                if (bank_univ[a]) r.flag = 1'b1;
                else if (v < 0 || v >= CAPACITY) r.status = bvs_pkg::STATUS_RANGE;
                else r.flag = bank_words[a][v / 64][v % 64];
            end
            bvs_pkg::FUNC_NEXT: begin
                start = (v < -1 ? -1 : v) + 1;
                found = -1;
                if (start < CAPACITY) begin
                    if (bank_univ[a]) found = start;
                    else for (int e = start; e < CAPACITY && found < 0; e++)
                        if (bank_words[a][e / 64][e % 64]) found = e;
                end
                if (found >= 0) begin
                    r.flag = 1'b1;
                    r.position = found[9:0];
                end
            end
            bvs_pkg::FUNC_UNION: begin
                if (!bank_univ[a]) begin
                    if (bank_univ[b]) bank_univ[a] = 1'b1;
                    else for (int i = 0; i < NWORDS; i++)
                        bank_words[a][i] |= bank_words[b][i];
                end
            end
            bvs_pkg::FUNC_INTER: begin
                if (bank_univ[a]) begin
                    for (int i = 0; i < NWORDS; i++) tmp[i] = bank_words[b][i];
                    for (int i = 0; i < NWORDS; i++) bank_words[a][i] = tmp[i];
                    bank_univ[a] = bank_univ[b];
                end else if (!bank_univ[b]) begin
                    for (int i = 0; i < NWORDS; i++)
                        bank_words[a][i] &= bank_words[b][i];
                end
            end
            bvs_pkg::FUNC_SUB: begin
                if (bank_univ[a]) r.status = bvs_pkg::STATUS_UNIV;
                else if (bank_univ[b])
                    for (int i = 0; i < NWORDS; i++) bank_words[a][i] = '0;
                else begin
                    for (int i = 0; i < NWORDS; i++) tmp[i] = bank_words[b][i];
                    for (int i = 0; i < NWORDS; i++) bank_words[a][i] &= ~tmp[i];
                end
            end
            bvs_pkg::FUNC_EQUAL: begin
                if (bank_univ[a] || bank_univ[b]) r.flag = bank_univ[a] && bank_univ[b];
                else begin
                    r.flag = 1'b1;
                    for (int i = 0; i < NWORDS; i++)
                        if (bank_words[a][i] != bank_words[b][i]) r.flag = 1'b0;
                end
            end
            bvs_pkg::FUNC_MKUNIV: bank_univ[a] = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Sends one transaction after a random gap and records its expected result.
    task automatic send_op(logic [3:0] func, logic [2:0] sa, logic [2:0] sb,
                           logic signed [10:0] val);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_set_a <= sa;
        s_set_b <= sb;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_set_op(func, sa, sb, val));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (NWORDS + 8) @(posedge aclk);
    endtask

    // Directed: edges of the value field, every operation, universal rules.
    task automatic test_directed();
        send_op(bvs_pkg::FUNC_ADD, 3'd0, 3'd0, 11'sd0);
        send_op(bvs_pkg::FUNC_ADD, 3'd0, 3'd0, 11'sd1023);
        send_op(bvs_pkg::FUNC_ADD, 3'd0, 3'd0, -11'sd1);
        send_op(bvs_pkg::FUNC_ADD, 3'd0, 3'd0, 11'sh400);
        send_op(bvs_pkg::FUNC_HAS, 3'd0, 3'd0, 11'sd1023);
        send_op(bvs_pkg::FUNC_HAS, 3'd0, 3'd0, -11'sd5);
        send_op(bvs_pkg::FUNC_NEXT, 3'd0, 3'd0, 11'sh400);
        send_op(bvs_pkg::FUNC_NEXT, 3'd0, 3'd0, 11'sd0);
        send_op(bvs_pkg::FUNC_NEXT, 3'd0, 3'd0, 11'sd1023);
        send_op(bvs_pkg::FUNC_UNION, 3'd1, 3'd0, 11'sd0);
        send_op(bvs_pkg::FUNC_EQUAL, 3'd1, 3'd0, 11'sd0);
        send_op(bvs_pkg::FUNC_INTER, 3'd1, 3'd1, 11'sd0);
        send_op(bvs_pkg::FUNC_SUB, 3'd1, 3'd1, 11'sd0);
        send_op(bvs_pkg::FUNC_MKUNIV, 3'd7, 3'd0, 11'sd0);
        send_op(bvs_pkg::FUNC_ADD, 3'd7, 3'd0, 11'sd5);
        send_op(bvs_pkg::FUNC_HAS, 3'd7, 3'd0, -11'sd48);
        send_op(bvs_pkg::FUNC_NEXT, 3'd7, 3'd0, 11'sd1022);
        send_op(bvs_pkg::FUNC_CLEAR, 3'd7, 3'd0, 11'sd0);
        send_op(bvs_pkg::FUNC_SUB, 3'd7, 3'd0, 11'sd0);
        send_op(bvs_pkg::FUNC_SUB, 3'd0, 3'd7, 11'sd0);
        send_op(bvs_pkg::FUNC_UNION, 3'd2, 3'd7, 11'sd0);
        send_op(bvs_pkg::FUNC_INTER, 3'd7, 3'd0, 11'sd0);
        send_op(bvs_pkg::FUNC_EQUAL, 3'd2, 3'd7, 11'sd0);
        send_op(4'd15, 3'd3, 3'd4, 11'sd7);
        send_op(bvs_pkg::FUNC_CLEAR, 3'd0, 3'd0, 11'sd0);
    endtask

    // Random: mostly adds and queries with set algebra, a few universal marks.
    task automatic test_random(int count);
        int sel;
        logic [3:0] func;
        logic signed [10:0] val;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) func = bvs_pkg::FUNC_ADD;
            else if (sel < 42) func = bvs_pkg::FUNC_HAS;
            else if (sel < 54) func = bvs_pkg::FUNC_NEXT;
            else if (sel < 62) func = bvs_pkg::FUNC_UNION;
            else if (sel < 70) func = bvs_pkg::FUNC_INTER;
            else if (sel < 77) func = bvs_pkg::FUNC_SUB;
            else if (sel < 85) func = bvs_pkg::FUNC_EQUAL;
            else if (sel < 91) func = bvs_pkg::FUNC_CLEAR;
            else if (sel < 95) func = bvs_pkg::FUNC_MKUNIV;
            else func = 4'($urandom_range(0, 15));
            sel = $urandom_range(0, 9);
            if (sel < 7) val = 11'($urandom_range(0, 1023));
            else val = 11'($urandom);
            if (n % 150 == 149) wait_drained();
            send_op(func, 3'($urandom), 3'($urandom), val);
        end
    endtask

    // Result checker; the receiver draws for every result how many cycles it waits.
    always @(posedge aclk) begin
        set_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_flag !== want.flag) report_mismatch("flag", m_flag, want.flag);
                if (m_position !== want.position)
                    report_mismatch("position", m_position, want.position);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
            end
        end
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_wait <= $urandom_range(0, 17);
        end else if (m_valid && m_ready) begin
            want.flag = 1'b0;
            ready_wait <= $urandom_range(0, 17);
            m_ready    <= 1'b0;
        end else if (m_valid && !m_ready) begin
            if (ready_wait == 0) m_ready <= 1'b1;
            else ready_wait <= ready_wait - 1;
        end
    end

    // Watchdog over the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func  = '0;
        s_set_a = '0;
        s_set_b = '0;
        s_value = '0;
        for (int s = 0; s < NSETS; s++) begin
            bank_univ[s] = 1'b0;
            for (int w = 0; w < NWORDS; w++) bank_words[s][w] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        wait_drained();
        test_random(430);
        wait_drained();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
